@@ src/multi_voice_sample_mixer_core_macros.svh @@
// Assertion macros used by the mixer RTL.
`ifndef MULTI_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH
`define MULTI_VOICE_SAMPLE_MIXER_CORE_MACROS_SVH
`ifndef SYNTH
`define MVSM_ASSERT_IMP(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) \
        else $error("assertion failed");
`define MVSM_ASSERT_NXT(label, clk, rst_n, a, c) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) \
        else $error("assertion failed");
`else
`define MVSM_ASSERT_IMP(label, clk, rst_n, a, c)
`define MVSM_ASSERT_NXT(label, clk, rst_n, a, c)
`endif
`endif

@@ src/mvsm_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none
package mvsm_pkg;
    typedef enum logic [2:0] {
        OP_WRITE    = 3'd0,
        OP_ADD_CLIP = 3'd1,
        OP_PLAY     = 3'd2,
        OP_STOP     = 3'd3,
        OP_STOP_ALL = 3'd4,
        OP_SET_GAIN = 3'd5,
        OP_TICK     = 3'd6,
        OP_UNUSED   = 3'd7
    } op_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_VREAD,
        ST_CREAD,
        ST_SREAD,
        ST_MAC,
        ST_ROUND,
        ST_DONE
    } state_t;

    localparam int unsigned MAX_CLIP_LEN = 65536;
endpackage
`default_nettype wire

@@ src/multi_voice_sample_mixer_core.sv @@
`timescale 1ns / 1ps
`default_nettype none
// Multi-voice stereo sample-playback mixer.
// The input channel (in_valid/in_ready) carries one command beat: op together
// with its operand fields. The output channel (out_valid/out_ready) returns
// exactly one result beat per command: status, handle and, for a tick, the
// mixed stereo frame. Commands are processed one at a time.
// Every command other than a tick passes through the done state, which
// registers its result; the voice control words sit in flip-flops and are
// searched in that one step.
// A tick walks every voice slot in order, idle or not; each slot takes four
// steps (voice read, clip read, sample memory read, multiply-accumulate), and
// one rounding step follows, which registers the mixed frame. The sample
// memory port has a registered read, and the slots share a single multiplier
// pair.
// The result sits in an output register and the next command beat is taken
// on the cycle after the previous result has been handed over.
// A stalled receiver holds the result and blocks new commands.
// Reset clears the clip count, the voice active and used bits, the handle
// counter and the control state. Sample, clip and voice payload memories are
// not cleared; reading a never written sample is outside the contract.
module multi_voice_sample_mixer_core #(
    parameter int VOICES        = 8,
    parameter int CLIPS         = 16,
    parameter int SAMPLE_FRAMES = 65536,
    parameter int SAMPLE_BITS   = 16
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               in_valid,
    output logic                    in_ready,
    input  wire logic [2:0]         op,
    input  wire logic [15:0]        address,
    input  wire logic [16:0]        clip_length,
    input  wire logic signed [15:0] left_in,
    input  wire logic signed [15:0] right_in,
    input  wire logic [3:0]         clip_index,
    input  wire logic               loop_flag,
    input  wire logic [15:0]        gain,
    input  wire logic [15:0]        sound_handle,
    output logic                    out_valid,
    input  wire logic               out_ready,
    output logic                    status,
    output logic [15:0]             handle,
    output logic signed [15:0]      left_out,
    output logic signed [15:0]      right_out
);
    import mvsm_pkg::*;

    localparam int AW = (SAMPLE_FRAMES > 1) ? $clog2(SAMPLE_FRAMES) : 1;
    localparam int VW = (VOICES > 1) ? $clog2(VOICES) : 1;
    localparam int CW = (CLIPS > 1) ? $clog2(CLIPS) : 1;
    localparam int NW = $clog2(CLIPS + 1);
    localparam int DROP = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
    localparam logic [15:0] KEEP = 16'hFFFF << DROP;
    localparam int ACCW = 34 + VW;

    // Memories.
    logic [15:0] smp_l_mem [SAMPLE_FRAMES];
    logic [15:0] smp_r_mem [SAMPLE_FRAMES];
    logic [15:0] clip_start_mem [CLIPS];
    logic [16:0] clip_frames_mem [CLIPS];

    // Voice state: control bits in flip-flops, payload in arrays.
    logic [VOICES-1:0] active_reg, active_next;
    logic [VOICES-1:0] used_reg, used_next;
    logic [VOICES-1:0] loop_arr;
    logic [3:0]  vclip_arr [VOICES];
    logic [16:0] vpos_arr  [VOICES];
    logic [15:0] vgain_arr [VOICES];
    logic [15:0] vhandle_arr [VOICES];

    logic [NW-1:0] clip_count_reg;
    logic [15:0]   next_handle_reg;
    state_t        state_reg, state_next;
    logic [VW-1:0] slot_reg;

    // Latched command.
    op_t         op_reg;
    logic [15:0] addr_reg, gain_reg, sh_reg;
    logic [16:0] len_reg;
    logic [15:0] lin_reg, rin_reg;
    logic [3:0]  cidx_reg;
    logic        loop_reg;

    // Tick pipeline registers.
    logic [3:0]  cur_clip_reg;
    logic [16:0] cur_pos_reg;
    logic [15:0] cur_gain_reg;
    logic        cur_loop_reg;
    logic        cur_skip_reg;
    logic [15:0] cstart_rd_reg;
    logic [16:0] cframes_rd_reg;
    logic [15:0] sl_rd_reg, sr_rd_reg;
    logic signed [ACCW-1:0] accl_reg, accr_reg;

    logic        out_valid_reg;
    logic        status_reg;
    logic [15:0] handle_reg, lo_reg, ro_reg;

    logic accept;
    assign in_ready = (state_reg == ST_IDLE) && !out_valid_reg;
    assign accept   = in_valid && in_ready;
    assign out_valid = out_valid_reg;
    assign status    = status_reg;
    assign handle    = handle_reg;
    assign left_out  = lo_reg;
    assign right_out = ro_reg;

    // Free slot and handle lookup (priority to the lowest slot).
    logic          free_found, hit_found;
    logic [VW-1:0] free_slot, hit_slot;
    always_comb
    begin
        free_found = 1'b0;
        free_slot  = '0;
        hit_found  = 1'b0;
        hit_slot   = '0;
        for (int v = VOICES - 1; v >= 0; v--)
        begin
            if (!active_reg[v])
            begin
                free_found = 1'b1;
                free_slot  = VW'(v);
            end
            if (used_reg[v] && vhandle_arr[v] == sh_reg)
            begin
                hit_found = 1'b1;
                hit_slot  = VW'(v);
            end
        end
    end

    // A voice only ever holds a clip index below the clip count.
    logic [CW-1:0] cur_c;
    assign cur_c = CW'(cur_clip_reg);

    logic        wrap_now, end_now;
    logic [16:0] eff_pos;
    logic [31:0] sum_addr;
    assign end_now  = cur_pos_reg >= cframes_rd_reg;
    assign wrap_now = end_now && cur_loop_reg;
    assign eff_pos  = wrap_now ? 17'd0 : cur_pos_reg;
    assign sum_addr = 32'(cstart_rd_reg) + 32'(eff_pos);

    logic signed [31:0] pl, pr;
    assign pl = $signed(sl_rd_reg) * $signed({1'b0, cur_gain_reg});
    assign pr = $signed(sr_rd_reg) * $signed({1'b0, cur_gain_reg});

    logic clip_bad;
    assign clip_bad = (len_reg == 17'd0) || (32'(len_reg) > MAX_CLIP_LEN)
                      || (32'(clip_count_reg) >= CLIPS);

    function automatic logic [15:0] clamp_mix(input logic signed [ACCW-1:0] s);
        logic signed [ACCW-1:0] q;
        begin
            q = s >>> 14;
            if (q > 32767)
                clamp_mix = 16'h7FFF;
            else if (q < -32768)
                clamp_mix = 16'h8000;
            else
                clamp_mix = q[15:0];
        end
    endfunction

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:  if (accept) state_next = (op == OP_TICK) ? ST_VREAD : ST_DONE;
            ST_VREAD: state_next = ST_CREAD;
            ST_CREAD: state_next = ST_SREAD;
            ST_SREAD: state_next = ST_MAC;
            ST_MAC:   state_next = (slot_reg == VW'(VOICES - 1)) ? ST_ROUND : ST_VREAD;
            ST_ROUND: state_next = ST_IDLE;
            ST_DONE:  state_next = ST_IDLE;
            default:  state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        active_next = active_reg;
        used_next   = used_reg;
        if (state_reg == ST_DONE)
        begin
            unique case (op_reg)
                OP_PLAY:
                    if (32'(cidx_reg) < 32'(clip_count_reg) && free_found)
                    begin
                        active_next[free_slot] = 1'b1;
                        used_next[free_slot]   = 1'b1;
                    end
                OP_STOP:     if (hit_found) active_next[hit_slot] = 1'b0;
                OP_STOP_ALL: active_next = '0;
                default: ;
            endcase
        end
        else if (state_reg == ST_SREAD && !cur_skip_reg && end_now && !cur_loop_reg)
            active_next[slot_reg] = 1'b0;
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            active_reg      <= '0;
            used_reg        <= '0;
            clip_count_reg  <= '0;
            next_handle_reg <= '0;
            out_valid_reg   <= 1'b0;
            slot_reg        <= '0;
        end
        else
        begin
            state_reg  <= state_next;
            active_reg <= active_next;
            used_reg   <= used_next;
            if (out_valid_reg && out_ready)
                out_valid_reg <= 1'b0;
            if (state_reg == ST_DONE || state_reg == ST_ROUND)
                out_valid_reg <= 1'b1;
            if (accept)
                slot_reg <= '0;
            else if (state_reg == ST_MAC)
                slot_reg <= slot_reg + VW'(1);
            if (state_reg == ST_DONE && op_reg == OP_ADD_CLIP && !clip_bad)
                clip_count_reg <= clip_count_reg + NW'(1);
            if (state_reg == ST_DONE && op_reg == OP_PLAY
                && 32'(cidx_reg) < 32'(clip_count_reg) && free_found)
                next_handle_reg <= next_handle_reg + 16'd1;
        end
    end

    // Payload registers and memories.
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            op_reg   <= op_t'(op);
            addr_reg <= address;
            len_reg  <= clip_length;
            lin_reg  <= left_in & KEEP;
            rin_reg  <= right_in & KEEP;
            cidx_reg <= clip_index;
            loop_reg <= loop_flag;
            gain_reg <= gain;
            sh_reg   <= sound_handle;
            accl_reg <= '0;
            accr_reg <= '0;
        end
        unique case (state_reg)
            ST_DONE:
            begin
                status_reg <= 1'b0;
                handle_reg <= '0;
                lo_reg     <= '0;
                ro_reg     <= '0;
                unique case (op_reg)
                    OP_WRITE:
                    begin
                        smp_l_mem[AW'(addr_reg)] <= lin_reg;
                        smp_r_mem[AW'(addr_reg)] <= rin_reg;
                    end
                    OP_ADD_CLIP:
                        if (clip_bad)
                            status_reg <= 1'b1;
                        else
                        begin
                            clip_start_mem[CW'(clip_count_reg)]  <= addr_reg;
                            clip_frames_mem[CW'(clip_count_reg)] <= len_reg;
                            handle_reg <= 16'(clip_count_reg);
                        end
                    OP_PLAY:
                        if (32'(cidx_reg) < 32'(clip_count_reg) && free_found)
                        begin
                            loop_arr[free_slot]    <= loop_reg;
                            vclip_arr[free_slot]   <= cidx_reg;
                            vpos_arr[free_slot]    <= '0;
                            vgain_arr[free_slot]   <= gain_reg;
                            vhandle_arr[free_slot] <= next_handle_reg;
                            handle_reg <= next_handle_reg;
                        end
                        else
                            status_reg <= 1'b1;
                    OP_STOP:     if (!hit_found) status_reg <= 1'b1;
                    OP_SET_GAIN:
                        if (hit_found) vgain_arr[hit_slot] <= gain_reg;
                        else status_reg <= 1'b1;
                    OP_STOP_ALL: ;
                    OP_TICK:     ;
                    OP_UNUSED:   status_reg <= 1'b1;
                    default:     status_reg <= 1'b1;
                endcase
            end
            ST_VREAD:
            begin
                cur_clip_reg <= vclip_arr[slot_reg];
                cur_pos_reg  <= vpos_arr[slot_reg];
                cur_gain_reg <= vgain_arr[slot_reg];
                cur_loop_reg <= loop_arr[slot_reg];
                cur_skip_reg <= !active_reg[slot_reg];
            end
            ST_CREAD:
            begin
                cstart_rd_reg  <= clip_start_mem[cur_c];
                cframes_rd_reg <= clip_frames_mem[cur_c];
            end
            ST_SREAD:
            begin
                sl_rd_reg <= smp_l_mem[AW'(sum_addr)];
                sr_rd_reg <= smp_r_mem[AW'(sum_addr)];
                if (!cur_skip_reg && end_now && !cur_loop_reg)
                    cur_skip_reg <= 1'b1;
                else if (!cur_skip_reg)
                    vpos_arr[slot_reg] <= eff_pos + 17'd1;
            end
            ST_MAC:
                if (!cur_skip_reg)
                begin
                    accl_reg <= accl_reg + ACCW'(pl);
                    accr_reg <= accr_reg + ACCW'(pr);
                end
            ST_ROUND:
            begin
                status_reg <= 1'b0;
                handle_reg <= '0;
                lo_reg     <= clamp_mix(accl_reg);
                ro_reg     <= clamp_mix(accr_reg);
            end
            ST_IDLE: ;
            default: ;
        endcase
    end

`include "multi_voice_sample_mixer_core_macros.svh"
    `MVSM_ASSERT_IMP(a_no_accept_busy, clk, rst_n, out_valid_reg, !in_ready)
    `MVSM_ASSERT_NXT(a_done_result, clk, rst_n, state_reg == ST_DONE, out_valid_reg)
    `MVSM_ASSERT_IMP(a_active_used, clk, rst_n, 1'b1, (active_reg & ~used_reg) == '0)
    `MVSM_ASSERT_IMP(a_clip_bound, clk, rst_n, 1'b1, 32'(clip_count_reg) <= CLIPS)
endmodule
`default_nettype wire

@@ test/tb_top.sv @@
`timescale 1ns / 1ps
// Self-checking bench for the multi-voice mixer core. A behavioural mirror of
// the mixer tracks samples, clips and voices and predicts every result beat.
// Sample frames a clip can reach are written before the clip is added, so no
// unwritten frame is ever mixed.
module tb_top;
    import mvsm_pkg::*;

    localparam int NV = 8;
    localparam int NC = 16;
    localparam int WATCHDOG_LIMIT = 20000;

    typedef struct packed {
        logic        status;
        logic [15:0] handle;
        logic [15:0] left;
        logic [15:0] right;
    } mix_result_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_ready;
    logic [2:0] op = '0;
    logic [15:0] address = '0;
    logic [16:0] clip_length = '0;
    logic signed [15:0] left_in = '0;
    logic signed [15:0] right_in = '0;
    logic [3:0] clip_index = '0;
    logic loop_flag = 1'b0;
    logic [15:0] gain = '0;
    logic [15:0] sound_handle = '0;
    logic out_valid;
    logic out_ready = 1'b0;
    logic status;
    logic [15:0] handle;
    logic signed [15:0] left_out;
    logic signed [15:0] right_out;

    always #1 clk = ~clk;

    multi_voice_sample_mixer_core dut (.*);

    // Mirror of the mixer state.
    logic [15:0] m_left [int];
    logic [15:0] m_right [int];
    logic [15:0] m_clip_start [NC];
    logic [16:0] m_clip_frames [NC];
    int unsigned m_clip_count = 0;
    bit m_active [NV];
    bit m_used [NV];
    bit m_loop [NV];
    logic [3:0] m_vclip [NV];
    logic [16:0] m_pos [NV];
    logic [15:0] m_gain [NV];
    logic [15:0] m_vhandle [NV];
    logic [15:0] m_next_handle = '0;

    mix_result_t pending_results [$];
    int errors = 0;
    int beats_sent = 0;
    int beats_checked = 0;
    int ticks_sent = 0;
    int idle_cycles = 0;
    bit stall_receiver = 1'b1;

    function automatic logic [15:0] clamp_mix(longint acc);
        longint q;
        q = acc >>> 14;
        if (q > 32767) q = 32767;
        if (q < -32768) q = -32768;
        return q[15:0];
    endfunction

    function automatic int find_voice(logic [15:0] h);
        for (int v = 0; v < NV; v++)
            if (m_used[v] && m_vhandle[v] == h) return v;
        return -1;
    endfunction

    // Updates the mirror for one command and returns the expected beat.
    function automatic mix_result_t mix_predict(logic [2:0] c_op, logic [15:0] c_addr,
            logic [16:0] c_len, logic [15:0] c_l, logic [15:0] c_r, logic [3:0] c_idx,
            bit c_loop, logic [15:0] c_gain, logic [15:0] c_sh);
        mix_result_t r;
        longint sl;
        longint sr;
        int v;
        logic [15:0] a;
        r = '0;
        case (op_t'(c_op))
            OP_WRITE: begin
                m_left[c_addr] = c_l;
                m_right[c_addr] = c_r;
            end
            OP_ADD_CLIP: begin
                if (c_len == 0 || c_len > MAX_CLIP_LEN || m_clip_count >= NC) r.status = 1'b1;
                else begin
                    m_clip_start[m_clip_count] = c_addr;
                    m_clip_frames[m_clip_count] = c_len;
                    r.handle = 16'(m_clip_count);
                    m_clip_count++;
                end
            end
            OP_PLAY: begin
                r.status = 1'b1;
                if (c_idx < m_clip_count) begin
                    for (v = 0; v < NV; v++) begin
                        if (!m_active[v]) begin
                            m_active[v] = 1'b1;
                            m_used[v] = 1'b1;
                            m_loop[v] = c_loop;
                            m_vclip[v] = c_idx;
                            m_pos[v] = '0;
                            m_gain[v] = c_gain;
                            m_vhandle[v] = m_next_handle;
                            r.handle = m_next_handle;
                            m_next_handle++;
                            r.status = 1'b0;
                            break;
                        end
                    end
                end
            end
            OP_STOP: begin
                v = find_voice(c_sh);
                if (v < 0) r.status = 1'b1;
                else m_active[v] = 1'b0;
            end
            OP_STOP_ALL: for (v = 0; v < NV; v++) m_active[v] = 1'b0;
            OP_SET_GAIN: begin
                v = find_voice(c_sh);
                if (v < 0) r.status = 1'b1;
                else m_gain[v] = c_gain;
            end
            OP_TICK: begin
                sl = 0;
                sr = 0;
                for (v = 0; v < NV; v++) begin
                    if (!m_active[v]) continue;
                    if (m_pos[v] >= m_clip_frames[m_vclip[v]]) begin
                        if (m_loop[v]) m_pos[v] = '0;
                        else begin
                            m_active[v] = 1'b0;
                            continue;
                        end
                    end
                    a = m_clip_start[m_vclip[v]] + m_pos[v][15:0];
                    sl += longint'($signed(m_left.exists(a) ? m_left[a] : 16'd0))
                          * longint'(m_gain[v]);
                    sr += longint'($signed(m_right.exists(a) ? m_right[a] : 16'd0))
                          * longint'(m_gain[v]);
                    m_pos[v] = m_pos[v] + 1'b1;
                end
                r.left = clamp_mix(sl);
                r.right = clamp_mix(sr);
            end
            default: r.status = 1'b1;
        endcase
        return r;
    endfunction

    task automatic report_mismatch(string what, logic [15:0] got, logic [15:0] want);
        $display("mismatch on beat %0d: %s got %h expected %h", beats_checked, what, got, want);
        errors++;
    endtask

    // Sends one command beat after a random gap and logs its expected result.
    // Valid stays high after the beat until the next call either drops it or
    // replaces the payload, so each signal is assigned once per time step.
    task automatic send_command(logic [2:0] c_op, logic [15:0] c_addr = '0,
            logic [16:0] c_len = '0, logic [15:0] c_l = '0, logic [15:0] c_r = '0,
            logic [3:0] c_idx = '0, bit c_loop = 1'b0, logic [15:0] c_gain = '0,
            logic [15:0] c_sh = '0);
        int gap;
        gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(0, 15);
        if (gap != 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        op <= c_op;
        address <= c_addr;
        clip_length <= c_len;
        left_in <= c_l;
        right_in <= c_r;
        clip_index <= c_idx;
        loop_flag <= c_loop;
        gain <= c_gain;
        sound_handle <= c_sh;
        in_valid <= 1'b1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        pending_results = {pending_results, mix_predict(c_op, c_addr, c_len, c_l, c_r,
                                                        c_idx, c_loop, c_gain, c_sh)};
        beats_sent++;
        if (c_op == OP_TICK) ticks_sent++;
        @(negedge clk);
    endtask

    // Receiver: random stalls drawn per beat, outputs sampled at the rising edge.
    initial begin : receiver
        int hold;
        forever begin
            @(negedge clk);
            hold = stall_receiver ? $urandom_range(0, 15) : 0;
            if (hold != 0) begin
                out_ready <= 1'b0;
                repeat (hold) @(negedge clk);
            end
            out_ready <= 1'b1;
            @(posedge clk);
            while (!out_valid) @(posedge clk);
        end
    end

    always @(posedge clk) begin : result_checker
        mix_result_t want;
        if (rst_n && out_valid && out_ready) begin
            if (pending_results.size() == 0) begin
                report_mismatch("unexpected beat", handle, 16'd0);
            end else begin
                want = pending_results.pop_front();
                if (status !== want.status) report_mismatch("status", status, want.status);
                if (handle !== want.handle) report_mismatch("handle", handle, want.handle);
                if (left_out !== want.left) report_mismatch("left", left_out, want.left);
                if (right_out !== want.right) report_mismatch("right", right_out, want.right);
            end
            beats_checked++;
        end
    end

    // Watchdog: too long without any beat accepted on either side ends the run.
    always @(posedge clk) begin : watchdog
        if ((in_valid && in_ready) || (out_valid && out_ready)) idle_cycles <= 0;
        else if (rst_n) idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("timeout with %0d results outstanding", pending_results.size());
            $display("FAIL");
            $finish;
        end
    end

    // Fills a region of sample memory with random frames.
    task automatic fill_samples(logic [15:0] base, int frames);
        for (int i = 0; i < frames; i++)
            send_command(OP_WRITE, base + i[15:0], 17'($urandom), 16'($urandom),
                         16'($urandom));
    endtask

    // Extremes of the sample range, address wrap, clip rejections, failed lookups
    // and the unused op, all before any voice plays.
    task automatic test_directed_setup();
        send_command(OP_WRITE, 16'hFFFF, '0, 16'h7FFF, 16'h8000);
        send_command(OP_WRITE, 16'h0000, '0, 16'h8000, 16'h7FFF);
        send_command(OP_WRITE, 16'h0001, 17'h1FFFF, 16'hFFFF, 16'h0001);
        send_command(OP_PLAY, '0, '0, '0, '0, 4'd0, 1'b0, 16'h4000);   // unknown clip
        send_command(OP_ADD_CLIP, 16'hFFFF, 17'd0);                    // length zero
        send_command(OP_ADD_CLIP, 16'hFFFF, 17'd65537);                // too long
        send_command(OP_ADD_CLIP, 16'hFFFF, 17'h1FFFF);                // too long
        send_command(OP_ADD_CLIP, 16'hFFFF, 17'd3);                    // wraps to frame 1
        send_command(OP_UNUSED, 16'hFFFF, 17'h1FFFF, 16'hFFFF, 16'hFFFF, 4'hF, 1'b1,
                     16'hFFFF, 16'hFFFF);
        send_command(OP_STOP, '0, '0, '0, '0, '0, 1'b0, '0, 16'h0000);     // no such handle
        send_command(OP_SET_GAIN, '0, '0, '0, '0, '0, 1'b0, 16'h1, 16'hFFFF);
    endtask

    // Saturation, looping, ending, stop, regain and a full voice pool.
    task automatic test_directed_voices();
        for (int i = 0; i < 9; i++)                 // ninth play finds the pool full
            send_command(OP_PLAY, '0, '0, '0, '0, 4'd0, i[0], 16'hFFFF);
        repeat (4) send_command(OP_TICK);
        send_command(OP_STOP, '0, '0, '0, '0, '0, 1'b0, '0, 16'd2);
        send_command(OP_SET_GAIN, '0, '0, '0, '0, '0, 1'b0, 16'h0000, 16'd1);
        send_command(OP_STOP, '0, '0, '0, '0, '0, 1'b0, '0, 16'd2);   // inactive slot still matches
        send_command(OP_TICK);
        send_command(OP_STOP_ALL);
        send_command(OP_TICK);
    endtask

    // Random sessions: mostly well-formed play/tick traffic over written
    // clips, with noise commands mixed in.
    task automatic test_random_traffic();
        int pick;
        logic [15:0] base;
        logic [16:0] len;
        base = 16'h1000;
        while (m_clip_count < NC) begin
            len = $urandom_range(0, 5) == 0 ? 17'd1 : 17'($urandom_range(2, 8));
            fill_samples(base, len);
            send_command(OP_ADD_CLIP, base, len);
            base += 16'd16;
        end
        send_command(OP_ADD_CLIP, base, 17'd4);     // table full
        while (beats_sent < 750) begin
            pick = $urandom_range(0, 99);
            if (pick < 45)
                send_command(OP_TICK, 16'($urandom), 17'($urandom), 16'($urandom),
                             16'($urandom));
            else if (pick < 65)
                send_command(OP_PLAY, 16'($urandom), 17'($urandom), 16'($urandom),
                             16'($urandom), 4'($urandom), 1'($urandom), 16'($urandom));
            else if (pick < 75)
                send_command(OP_STOP, '0, '0, '0, '0, '0, 1'b0, '0,
                             16'(m_next_handle - $urandom_range(1, 10)));
            else if (pick < 85)
                send_command(OP_SET_GAIN, '0, '0, '0, '0, '0, 1'b0, 16'($urandom),
                             $urandom_range(0, 3) == 0 ? 16'($urandom)
                                 : 16'(m_next_handle - $urandom_range(1, 10)));
            else if (pick < 90)
                send_command(OP_WRITE, 16'(16'h1000 + $urandom_range(0, 255)),
                             17'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 93) send_command(OP_STOP_ALL);
            else if (pick < 96) send_command(OP_UNUSED, 16'($urandom), 17'($urandom));
            else begin
                // A stretch of ticks with the receiver never stalling.
                stall_receiver = 1'b0;
                repeat (8) send_command(OP_TICK);
                stall_receiver = 1'b1;
            end
        end
    endtask

    initial begin
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_directed_setup();
        test_directed_voices();
        test_random_traffic();
        in_valid <= 1'b0;
        while (pending_results.size() != 0) @(posedge clk);
        repeat (50) @(posedge clk);
        $display("%0d command beats sent, %0d of them ticks; %0d results checked",
                 beats_sent, ticks_sent, beats_checked);
        if (errors == 0)
            $display("PASS");
        else
            $display("FAIL");
        $finish;
    end
endmodule

@@ multi_voice_sample_mixer_core.f @@
+incdir+src
src/mvsm_pkg.sv
src/multi_voice_sample_mixer_core.sv
test/tb_top.sv
